/* design/bnpci_pkg.sv */
// ----------------------------------------------------------------------------
// bnpci_pkg
// Shared types and constants for the BACnet NPCI address extract unit.
// ----------------------------------------------------------------------------
package bnpci_pkg;

    // Default sizing
    localparam int DEF_MAX_FRAME_LEN = 2048;
    localparam int DEF_ADDR_OCTETS   = 8;

    // Port widths
    localparam int LINK_W   = 3;
    localparam int BYTE_W   = 8;
    localparam int OFFSET_W = 12;
    localparam int NET_W    = 16;
    localparam int LEN_W    = 8;
    localparam int MAC_W    = 64;
    localparam int M_DATA_W = 200;
    localparam int START_W  = 5;

    // Link type codes
    localparam logic [LINK_W-1:0] LINK_IP     = 3'd0;
    localparam logic [LINK_W-1:0] LINK_ETH    = 3'd1;
    localparam logic [LINK_W-1:0] LINK_ARCNET = 3'd2;
    localparam logic [LINK_W-1:0] LINK_MSTP   = 3'd3;
    localparam logic [LINK_W-1:0] LINK_NO_PDU = 3'd4;

    // NPDU start offsets per link framing
    localparam logic [START_W-1:0] START_ETH     = 5'd17;
    localparam logic [START_W-1:0] START_ARCNET  = 5'd6;
    localparam logic [START_W-1:0] START_MSTP    = 5'd2;
    localparam logic [START_W-1:0] START_BVLC    = 5'd10;
    localparam logic [START_W-1:0] START_FWD     = 5'd16;
    localparam logic [START_W-1:0] START_DEFAULT = 5'd0;

    // BVLC header
    localparam logic [BYTE_W-1:0] BVLC_MARKER   = 8'h81;
    localparam logic [BYTE_W-1:0] BVLC_FWD_NPDU = 8'h04;
    localparam logic [BYTE_W-1:0] BVLC_FUNC_09  = 8'h09;
    localparam logic [BYTE_W-1:0] BVLC_FUNC_0A  = 8'h0A;
    localparam logic [BYTE_W-1:0] BVLC_FUNC_0B  = 8'h0B;
    localparam int BVLC_MARKER_POS = 6;
    localparam int BVLC_FUNC_POS   = 7;
    localparam int IP_MIN_LEN      = 10;

    // NPCI control bits
    localparam int CTRL_DNET_BIT = 5;
    localparam int CTRL_SNET_BIT = 3;

    // One input item
    typedef struct packed {
        logic [LINK_W-1:0] link_type;
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } in_item_t;

    // One summary result
    typedef struct packed {
        logic                npdu_found;
        logic [OFFSET_W-1:0] npdu_offset;
        logic                has_dnet;
        logic [NET_W-1:0]    dnet;
        logic [LEN_W-1:0]    dadr_len;
        logic [MAC_W-1:0]    dadr;
        logic                has_snet;
        logic [NET_W-1:0]    snet;
        logic [LEN_W-1:0]    sadr_len;
        logic [MAC_W-1:0]    sadr;
        logic                truncated;
        logic                addr_overflow;
    } npci_result_t;

endpackage

/* design/bacnet_npci_address_extract_unit.sv */
// ----------------------------------------------------------------------------
// bacnet_npci_address_extract_unit
// Parses a captured BACnet frame one octet per item and returns one summary
// of the NPDU start and the NPCI destination and source addresses.
// ----------------------------------------------------------------------------
//  Channel | Direction | Item
//  s_      | in        | one frame octet, link type on the first, tlast on the end
//  m_      | out       | one summary per frame, sent after the last octet
//
//  Octets move through an input register, the parser and a result register:
//  one item per cycle while no held summary stalls a frame's last octet;
//  m_tvalid rises once the summary of the last octet is in the result register.
//  Reset (aresetn low at a clock edge) empties both registers and puts the
//  parser back to waiting for the first octet of a frame.
//  A stall on m_ holds the summary; the parser keeps taking octets and only
//  waits when the next frame's last octet arrives while the summary is held.
// ----------------------------------------------------------------------------
module bacnet_npci_address_extract_unit #(
    parameter int MAX_FRAME_LEN = bnpci_pkg::DEF_MAX_FRAME_LEN,
    parameter int ADDR_OCTETS   = bnpci_pkg::DEF_ADDR_OCTETS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bnpci_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] data_byte
    input  logic [bnpci_pkg::LINK_W-1:0]   s_tuser,   // [2:0] link_type
    input  logic                           s_tlast,   // last_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] npdu_found, [12:1] npdu_offset, [13] has_dnet, [29:14] dnet,
    // [37:30] dadr_len, [101:38] dadr, [102] has_snet, [118:103] snet,
    // [126:119] sadr_len, [190:127] sadr, [191] truncated,
    // [192] addr_overflow, [199:193] zero
    output logic [bnpci_pkg::M_DATA_W-1:0] m_tdata
);
    import bnpci_pkg::*;

    logic         item_valid;
    in_item_t     item;
    logic         item_take;
    logic         res_ready;
    logic         res_load;
    npci_result_t res;

    bnpci_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    bnpci_parser #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN),
        .ADDR_OCTETS   (ADDR_OCTETS)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .res_ready  (res_ready),
        .res_load   (res_load),
        .res        (res)
    );

    bnpci_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_load  (res_load),
        .res       (res),
        .res_ready (res_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

/* design/bnpci_in_reg.sv */
// ----------------------------------------------------------------------------
// bnpci_in_reg
// Input register: captures one frame octet item from the slave stream.
// ----------------------------------------------------------------------------
module bnpci_in_reg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bnpci_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] data_byte
    input  logic [bnpci_pkg::LINK_W-1:0]   s_tuser,   // [2:0] link_type
    input  logic                           s_tlast,   // last_byte
    output logic                           item_valid,
    output bnpci_pkg::in_item_t            item,
    input  logic                           item_take
);
    import bnpci_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    // Accept when empty or when the held item moves on this cycle
    assign s_tready = !valid_reg || item_take;

    // Hold valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    // Capture payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.link_type <= s_tuser;
            item_reg.data_byte <= s_tdata;
            item_reg.last_byte <= s_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* design/bnpci_parser.sv */
// ----------------------------------------------------------------------------
// bnpci_parser
// Per-octet header parser: tracks position, finds the NPDU start, captures
// the NPCI address fields and forms the summary on the last octet.
// ----------------------------------------------------------------------------
module bnpci_parser #(
    parameter int MAX_FRAME_LEN = bnpci_pkg::DEF_MAX_FRAME_LEN,
    parameter int ADDR_OCTETS   = bnpci_pkg::DEF_ADDR_OCTETS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    item_valid,
    input  bnpci_pkg::in_item_t     item,
    output logic                    item_take,
    input  logic                    res_ready,
    output logic                    res_load,
    output bnpci_pkg::npci_result_t res
);
    import bnpci_pkg::*;

    localparam int PW = $clog2(MAX_FRAME_LEN + 1);
    localparam int CW = ((PW > OFFSET_W) ? PW : OFFSET_W) + 1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT,
        PH_RUN,
        PH_NONE
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic [LINK_W-1:0]   link_reg, link_next;
    logic [START_W-1:0]  start_reg, start_next;
    logic [BYTE_W-1:0]   ctrl_reg, ctrl_next;
    logic [NET_W-1:0]    dnet_reg, dnet_next;
    logic [LEN_W-1:0]    dlen_reg, dlen_next;
    logic [MAC_W-1:0]    dmac_reg, dmac_next;
    logic [NET_W-1:0]    snet_reg, snet_next;
    logic [LEN_W-1:0]    slen_reg, slen_next;
    logic [MAC_W-1:0]    smac_reg, smac_next;

    // Current frame state, with the first octet opening a fresh frame
    phase_t              phase_c;
    logic [PW-1:0]       pos_c;
    logic [START_W-1:0]  start_c;
    logic [BYTE_W-1:0]   ctrl_c;
    logic [NET_W-1:0]    dnet_c;
    logic [LEN_W-1:0]    dlen_c;
    logic [MAC_W-1:0]    dmac_c;
    logic [NET_W-1:0]    snet_c;
    logic [LEN_W-1:0]    slen_c;
    logic [MAC_W-1:0]    smac_c;

    logic [CW-1:0]       rel;
    logic [CW-1:0]       sbase;
    logic [CW-1:0]       r_src;
    logic [CW-1:0]       frame_len;
    logic [CW-1:0]       avail;
    logic [CW-1:0]       sbase_f;
    logic                found;
    logic                hd;
    logic                hs;
    logic [BYTE_W-1:0]   b;

    // Advance unless a result is due and the output register is full and not being taken
    assign item_take = item_valid && (!item.last_byte || res_ready);
    assign res_load  = item_take && item.last_byte;
    assign b         = item.data_byte;

    // Open frame on first octet
    always_comb begin
        if (phase_reg == PH_IDLE) begin
            link_next = item.link_type;
            pos_c     = '0;
            ctrl_c    = '0;
            dnet_c    = '0;
            dlen_c    = '0;
            dmac_c    = '0;
            snet_c    = '0;
            slen_c    = '0;
            smac_c    = '0;
            unique case (item.link_type)
                LINK_IP: begin
                    start_c = START_DEFAULT;
                    phase_c = PH_WAIT;
                end
                LINK_ETH: begin
                    start_c = START_ETH;
                    phase_c = PH_RUN;
                end
                LINK_ARCNET: begin
                    start_c = START_ARCNET;
                    phase_c = PH_RUN;
                end
                LINK_MSTP: begin
                    start_c = START_MSTP;
                    phase_c = PH_RUN;
                end
                LINK_NO_PDU: begin
                    start_c = START_DEFAULT;
                    phase_c = PH_NONE;
                end
                default: begin
                    start_c = START_DEFAULT;
                    phase_c = PH_RUN;
                end
            endcase
        end else begin
            link_next = link_reg;
            pos_c     = pos_reg;
            start_c   = start_reg;
            phase_c   = phase_reg;
            ctrl_c    = ctrl_reg;
            dnet_c    = dnet_reg;
            dlen_c    = dlen_reg;
            dmac_c    = dmac_reg;
            snet_c    = snet_reg;
            slen_c    = slen_reg;
            smac_c    = smac_reg;
        end
    end

    // Take one octet
    always_comb begin
        phase_next = phase_c;
        pos_next   = pos_c;
        start_next = start_c;
        ctrl_next  = ctrl_c;
        dnet_next  = dnet_c;
        dlen_next  = dlen_c;
        dmac_next  = dmac_c;
        snet_next  = snet_c;
        slen_next  = slen_c;
        smac_next  = smac_c;
        rel        = CW'(pos_c) - CW'(start_c);
        sbase      = ctrl_c[CTRL_DNET_BIT] ? (CW'(5) + CW'(dlen_c)) : CW'(2);
        r_src      = rel - sbase;

        if (pos_c < PW'(MAX_FRAME_LEN)) begin
            pos_next = pos_c + PW'(1);
            if (phase_c == PH_WAIT) begin
                if (CW'(pos_c) == CW'(BVLC_MARKER_POS)) begin
                    if (b != BVLC_MARKER) begin
                        phase_next = PH_NONE;
                    end
                end else if (CW'(pos_c) == CW'(BVLC_FUNC_POS)) begin
                    if (b == BVLC_FUNC_09 || b == BVLC_FUNC_0A || b == BVLC_FUNC_0B) begin
                        start_next = START_BVLC;
                        phase_next = PH_RUN;
                    end else if (b == BVLC_FWD_NPDU) begin
                        start_next = START_FWD;
                        phase_next = PH_RUN;
                    end else begin
                        phase_next = PH_NONE;
                    end
                end
            end else if (phase_c == PH_RUN && CW'(pos_c) >= CW'(start_c)) begin
                if (rel == CW'(1)) begin
                    ctrl_next = b;
                end else if (rel >= CW'(2)) begin
                    // Destination net, length and MAC
                    if (ctrl_c[CTRL_DNET_BIT]) begin
                        if (rel == CW'(2)) begin
                            dnet_next = {b, 8'h00};
                        end else if (rel == CW'(3)) begin
                            dnet_next = dnet_c | {8'h00, b};
                        end else if (rel == CW'(4)) begin
                            dlen_next = b;
                        end else if (rel < sbase && (rel - CW'(5)) < CW'(ADDR_OCTETS)) begin
                            dmac_next = {dmac_c[MAC_W-BYTE_W-1:0], b};
                        end
                    end
                    // Source net, length and MAC
                    if (ctrl_c[CTRL_SNET_BIT] && rel >= sbase) begin
                        if (r_src == CW'(0)) begin
                            snet_next = {b, 8'h00};
                        end else if (r_src == CW'(1)) begin
                            snet_next = snet_c | {8'h00, b};
                        end else if (r_src == CW'(2)) begin
                            slen_next = b;
                        end else if (r_src < (CW'(3) + CW'(slen_c))
                                     && (r_src - CW'(3)) < CW'(ADDR_OCTETS)) begin
                            smac_next = {smac_c[MAC_W-BYTE_W-1:0], b};
                        end
                    end
                end
            end
        end
    end

    // Form the summary from the updated frame state
    always_comb begin
        frame_len = CW'(pos_next);
        found     = (phase_next == PH_RUN) && (CW'(start_next) < frame_len)
                    && !(link_next == LINK_IP && frame_len <= CW'(IP_MIN_LEN));
        avail     = frame_len - CW'(start_next);
        hd        = ctrl_next[CTRL_DNET_BIT];
        hs        = ctrl_next[CTRL_SNET_BIT];
        sbase_f   = hd ? (CW'(5) + CW'(dlen_next)) : CW'(2);
        res       = '0;
        if (!found) begin
            res.npdu_offset = frame_len[OFFSET_W-1:0];
        end else begin
            res.npdu_found  = 1'b1;
            res.npdu_offset = OFFSET_W'(start_next);
            if (avail >= CW'(2)) begin
                if (hd) begin
                    res.has_dnet = 1'b1;
                    res.dnet     = dnet_next;
                    res.dadr_len = dlen_next;
                    res.dadr     = dmac_next;
                    if (avail < sbase_f) begin
                        res.truncated = 1'b1;
                    end
                    if (dlen_next > LEN_W'(ADDR_OCTETS)) begin
                        res.addr_overflow = 1'b1;
                    end
                end
                if (hs) begin
                    res.has_snet = 1'b1;
                    res.snet     = snet_next;
                    res.sadr_len = slen_next;
                    res.sadr     = smac_next;
                    if (avail < (sbase_f + CW'(3) + CW'(slen_next))) begin
                        res.truncated = 1'b1;
                    end
                    if (slen_next > LEN_W'(ADDR_OCTETS)) begin
                        res.addr_overflow = 1'b1;
                    end
                end
            end
        end
    end

    // Hold parse phase; return to idle after the last octet
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else if (item_take) begin
            phase_reg <= item.last_byte ? PH_IDLE : phase_next;
        end
    end

    // Hold frame fields
    always_ff @(posedge aclk) begin
        if (item_take) begin
            pos_reg   <= pos_next;
            link_reg  <= link_next;
            start_reg <= start_next;
            ctrl_reg  <= ctrl_next;
            dnet_reg  <= dnet_next;
            dlen_reg  <= dlen_next;
            dmac_reg  <= dmac_next;
            snet_reg  <= snet_next;
            slen_reg  <= slen_next;
            smac_reg  <= smac_next;
        end
    end

endmodule

/* design/bnpci_out_reg.sv */
// ----------------------------------------------------------------------------
// bnpci_out_reg
// Result register: holds one summary item for the master stream.
// ----------------------------------------------------------------------------
module bnpci_out_reg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           res_load,
    input  bnpci_pkg::npci_result_t        res,
    output logic                           res_ready,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bnpci_pkg::M_DATA_W-1:0] m_tdata
);
    import bnpci_pkg::*;

    logic                valid_reg;
    logic [M_DATA_W-1:0] data_reg;

    assign res_ready = !valid_reg || m_tready;

    // Hold valid until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    // Pack result, first field lowest
    always_ff @(posedge aclk) begin
        if (res_load) begin
            data_reg <= {7'd0, res.addr_overflow, res.truncated, res.sadr, res.sadr_len,
                         res.snet, res.has_snet, res.dadr, res.dadr_len, res.dnet,
                         res.has_dnet, res.npdu_offset, res.npdu_found};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule
